// ===== src/assert_macros.svh =====
// Assertion macros shared by the palette expander modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define PITR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define PITR_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define PITR_ASSERT(lbl, clk, rst_n, prop, msg)

`define PITR_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ===== src/pitr_pkg.sv =====
// Types, codes and sizing constants of the palette expander.
package pitr_pkg;

  localparam int PAL_BYTES   = 1024;
  localparam int BANKS       = 4;
  localparam int BANK_ROWS   = (PAL_BYTES + BANKS - 1) / BANKS;
  localparam int ROW_W       = $clog2(BANK_ROWS);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [10:0] PAL_LIMIT = 11'(PAL_BYTES);

  localparam logic CMD_PAL_WRITE = 1'b0;
  localparam logic CMD_IMAGE     = 1'b1;

  localparam logic PF_RGBA32   = 1'b0;
  localparam logic PF_RGBA5551 = 1'b1;

  localparam logic [1:0] IMG_4BIT   = 2'd0;
  localparam logic [1:0] IMG_8BIT   = 2'd1;
  localparam logic [1:0] IMG_DIRECT = 2'd2;

  localparam logic [1:0] KIND_TWO = 2'd0;
  localparam logic [1:0] KIND_ONE = 2'd1;
  localparam logic [1:0] KIND_RAW = 2'd2;

  localparam logic REG_PALETTE_FORMAT = 1'b0;
  localparam logic REG_IMAGE_FORMAT   = 1'b1;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_PIX2,
    OP_PIX1,
    OP_RAW
  } op_e;

  typedef struct packed {
    logic       cmd;
    logic [9:0] palette_addr;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [1:0] out_kind;
    logic [7:0] first_red;
    logic [7:0] first_green;
    logic [7:0] first_blue;
    logic [7:0] first_alpha;
    logic [7:0] second_red;
    logic [7:0] second_green;
    logic [7:0] second_blue;
    logic [7:0] second_alpha;
    logic [7:0] raw_byte;
  } out_t;

  typedef struct packed {
    op_e        op;
    logic [9:0] addr;
    logic [7:0] data;
  } qent_t;

  typedef struct packed {
    logic  valid;
    qent_t entry;
  } push_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pix_t;

endpackage

// ===== src/pitr_ram.sv =====
// Generic RAM: one write port, two registered read ports.
module pitr_ram #(
  parameter int Width = 8,
  parameter int Depth = 256,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_a_i,
  input  logic [AddrW-1:0] raddr_b_i,
  output logic [Width-1:0] rdata_a_o,
  output logic [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== src/pitr_front.sv =====
// Front end: accepts requests and sorts them into queue operations.
module pitr_front import pitr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_t        in_data_i,
  input  logic [1:0] image_format_i,
  input  logic       queue_full_i,
  output push_t      push_o
);

  logic accept;
  logic drop;
  op_e  op;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    drop = 1'b0;
    op   = OP_WRITE;
    if (in_data_i.cmd == CMD_IMAGE) begin
      case (image_format_i)
        IMG_4BIT:   op = OP_PIX2;
        IMG_8BIT:   op = OP_PIX1;
        IMG_DIRECT: op = OP_RAW;
        default:    drop = 1'b1;
      endcase
    end
  end

  assign push_o.valid       = accept && !drop;
  assign push_o.entry.op    = op;
  assign push_o.entry.addr  = in_data_i.palette_addr;
  assign push_o.entry.data  = in_data_i.data_byte;

  `include "assert_macros.svh"

  `PITR_NEVER(a_push_needs_room, clk_i, rst_ni, push_o.valid && queue_full_i, "push into full queue")

endmodule

// ===== src/pitr_queue.sv =====
// Short queue between the front end and the back end.
module pitr_queue import pitr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  full_o,
  output logic  head_valid_o,
  output qent_t head_o,
  input  logic  pop_i
);

  qent_t             ent_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  localparam logic [QPTR_W-1:0] LastPtr = QPTR_W'(QUEUE_DEPTH - 1);
  localparam logic [QCNT_W-1:0] FullCnt = QCNT_W'(QUEUE_DEPTH);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i.valid) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i.valid && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i.valid && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      ent_q[wr_ptr_q] <= push_i.entry;
    end
  end

  assign full_o       = (count_q == FullCnt);
  assign head_valid_o = (count_q != '0);
  assign head_o       = ent_q[rd_ptr_q];

  `include "assert_macros.svh"

  `PITR_NEVER(a_pop_when_empty, clk_i, rst_ni, pop_i && (count_q == '0), "pop from empty queue")
  `PITR_NEVER(a_count_bound, clk_i, rst_ni, count_q > FullCnt, "queue count beyond depth")

endmodule

// ===== src/pitr_back.sv =====
// Back end: palette banks, lookup, colour decode and output register.
module pitr_back import pitr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  palette_format_i,
  input  logic  head_valid_i,
  input  qent_t head_i,
  output logic  pop_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output out_t  out_data_o
);

  function automatic logic [3:0] byte_ok(logic fmt16, logic [7:0] idx);
    logic [10:0] base;
    logic [3:0]  ok;
    base = fmt16 ? {2'b00, idx, 1'b0} : {1'b0, idx, 2'b00};
    for (int k = 0; k < 4; k++) begin
      ok[k] = ((base + 11'(k)) < PAL_LIMIT) && (!fmt16 || (k < 2));
    end
    return ok;
  endfunction

  function automatic pix_t decode(logic fmt16, logic half, logic [3:0] ok,
                                  logic [3:0][7:0] bytes);
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [15:0] w;
    pix_t        p;
    lo = (half ? bytes[2] : bytes[0]) & {8{ok[0]}};
    hi = (half ? bytes[3] : bytes[1]) & {8{ok[1]}};
    w  = {hi, lo};
    if (!fmt16) begin
      p.red   = bytes[0] & {8{ok[0]}};
      p.green = bytes[1] & {8{ok[1]}};
      p.blue  = bytes[2] & {8{ok[2]}};
      p.alpha = bytes[3] & {8{ok[3]}};
    end else begin
      p.red   = {w[4:0], 3'b000};
      p.green = {w[9:5], 3'b000};
      p.blue  = {w[14:10], 3'b000};
      p.alpha = w[15] ? 8'hFF : 8'h00;
    end
    return p;
  endfunction

  logic             fmt16;
  logic             is_wr;
  logic             s1_adv;
  logic             slot_free;
  logic             rd_issue;
  logic             wr_en;
  logic [7:0]       idx_a;
  logic [7:0]       idx_b;
  logic [7:0]       row_a8;
  logic [7:0]       row_b8;
  logic [3:0][7:0]  rd_a;
  logic [3:0][7:0]  rd_b;

  logic             s1_valid_q, s1_valid_d;
  op_e              s1_op_q;
  logic             s1_half_a_q;
  logic             s1_half_b_q;
  logic [3:0]       s1_ok_a_q;
  logic [3:0]       s1_ok_b_q;
  logic [7:0]       s1_raw_q;

  logic             out_valid_q, out_valid_d;
  out_t             out_data_q;
  out_t             fmt_out;
  pix_t             pix_a;
  pix_t             pix_b;

  assign fmt16     = (palette_format_i == PF_RGBA5551);
  assign is_wr     = (head_i.op == OP_WRITE);
  assign s1_adv    = !out_valid_q || out_ready_i;
  assign slot_free = !s1_valid_q || s1_adv;
  assign pop_o     = head_valid_i && (is_wr || slot_free);
  assign rd_issue  = pop_o && !is_wr;
  assign wr_en     = pop_o && is_wr && ({1'b0, head_i.addr} < PAL_LIMIT);

  assign idx_a  = (head_i.op == OP_PIX2) ? {4'h0, head_i.data[3:0]} : head_i.data;
  assign idx_b  = {4'h0, head_i.data[7:4]};
  assign row_a8 = fmt16 ? {1'b0, idx_a[7:1]} : idx_a;
  assign row_b8 = fmt16 ? {1'b0, idx_b[7:1]} : idx_b;

  for (genvar k = 0; k < BANKS; k++) begin : g_bank
    pitr_ram #(
      .Width (8),
      .Depth (BANK_ROWS)
    ) u_ram (
      .clk_i     (clk_i),
      .we_i      (wr_en && (head_i.addr[1:0] == 2'(k))),
      .waddr_i   (head_i.addr[ROW_W+1:2]),
      .wdata_i   (head_i.data),
      .re_i      (rd_issue),
      .raddr_a_i (row_a8[ROW_W-1:0]),
      .raddr_b_i (row_b8[ROW_W-1:0]),
      .rdata_a_o (rd_a[k]),
      .rdata_b_o (rd_b[k])
    );
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (rd_issue) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_issue) begin
      s1_op_q     <= head_i.op;
      s1_half_a_q <= fmt16 && idx_a[0];
      s1_half_b_q <= fmt16 && idx_b[0];
      s1_ok_a_q   <= byte_ok(fmt16, idx_a);
      s1_ok_b_q   <= byte_ok(fmt16, idx_b);
      s1_raw_q    <= head_i.data;
    end
  end

  assign pix_a = decode(fmt16, s1_half_a_q, s1_ok_a_q, rd_a);
  assign pix_b = decode(fmt16, s1_half_b_q, s1_ok_b_q, rd_b);

  always_comb begin
    fmt_out = '0;
    case (s1_op_q)
      OP_PIX2: begin
        fmt_out.out_kind     = KIND_TWO;
        fmt_out.first_red    = pix_a.red;
        fmt_out.first_green  = pix_a.green;
        fmt_out.first_blue   = pix_a.blue;
        fmt_out.first_alpha  = pix_a.alpha;
        fmt_out.second_red   = pix_b.red;
        fmt_out.second_green = pix_b.green;
        fmt_out.second_blue  = pix_b.blue;
        fmt_out.second_alpha = pix_b.alpha;
      end
      OP_PIX1: begin
        fmt_out.out_kind    = KIND_ONE;
        fmt_out.first_red   = pix_a.red;
        fmt_out.first_green = pix_a.green;
        fmt_out.first_blue  = pix_a.blue;
        fmt_out.first_alpha = pix_a.alpha;
      end
      OP_RAW: begin
        fmt_out.out_kind = KIND_RAW;
        fmt_out.raw_byte = s1_raw_q;
      end
      default: fmt_out = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      out_data_q <= fmt_out;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `include "assert_macros.svh"

  `PITR_NEVER(a_read_into_busy_slot, clk_i, rst_ni, rd_issue && s1_valid_q && !s1_adv, "lookup overruns stalled stage")
  `PITR_ASSERT(a_stalled_stage_holds, clk_i, rst_ni, s1_valid_q && !s1_adv |=> s1_valid_q, "stalled lookup lost")

endmodule

// ===== src/palette_index_to_rgba_unit.sv =====
// Top level of the indexed texture to RGBA palette expander.
// Sustains one request per cycle on both channels unless the output stalls. An
// image request passes the queue slot written at acceptance, the palette bank
// read register and the output register; a palette write is done when popped
// and gives no result. The rate is set by the palette store: four byte-wide
// banks of PAL_BYTES/4 rows, each with two read ports, so both entries of a
// 4-bit pixel pair are fetched in a single read. Palette writes and lookups
// are done in request order, so a lookup always sees every earlier write. Image
// requests made while image_format holds the undefined code are dropped.
module palette_index_to_rgba_unit import pitr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [1:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_t        in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_t       out_data_o
);

  logic       pal_fmt_q, pal_fmt_d;
  logic [1:0] img_fmt_q, img_fmt_d;
  push_t      push;
  logic       queue_full;
  logic       head_valid;
  qent_t      head;
  logic       pop;

  always_comb begin
    pal_fmt_d = pal_fmt_q;
    img_fmt_d = img_fmt_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_PALETTE_FORMAT: pal_fmt_d = cfg_wdata_i[0];
        REG_IMAGE_FORMAT:   img_fmt_d = cfg_wdata_i;
        default:            pal_fmt_d = pal_fmt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_fmt_q <= PF_RGBA32;
      img_fmt_q <= IMG_8BIT;
    end else begin
      pal_fmt_q <= pal_fmt_d;
      img_fmt_q <= img_fmt_d;
    end
  end

  pitr_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_data_i      (in_data_i),
    .image_format_i (img_fmt_q),
    .queue_full_i   (queue_full),
    .push_o         (push)
  );

  pitr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (queue_full),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  pitr_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .palette_format_i (pal_fmt_q),
    .head_valid_i     (head_valid),
    .head_i           (head),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_data_o       (out_data_o)
  );

endmodule
